>>> rtl/cdll_pkg.sv
// cdll_pkg: shared types and constants of the cursor doubly linked list
// op codes, status codes, default sizes and the data-read load flags
// no dependencies
package cdll_pkg;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_DATA_WIDTH  = 32;
    localparam int IO_WIDTH        = 32;
    localparam int OP_WIDTH        = 4;
    localparam int STATUS_WIDTH    = 2;
    localparam int COUNT_OUT_WIDTH = 5;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_INSERT     = 4'd2,
        OP_RIGHT      = 4'd3,
        OP_LEFT       = 4'd4,
        OP_DEL_FIRST  = 4'd5,
        OP_DEL_LAST   = 4'd6,
        OP_DEL_CURSOR = 4'd7,
        OP_CUR_FIRST  = 4'd8,
        OP_CUR_LAST   = 4'd9
    } t_op;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_END   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // which value registers take the word coming back from the data memory
    typedef struct packed {
        logic head;
        logic tail;
        logic cur;
    } t_load;

endpackage

>>> rtl/cdll_ram.sv
// cdll_ram: simple dual-port synchronous memory, one write and one read port
// read data registered; no reset, contents undefined
// no dependencies
module cdll_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [WIDTH-1:0] i_wd,
    input  logic [AW-1:0]    i_ra,
    output logic [WIDTH-1:0] o_rd
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_rd <= r_mem[i_ra];
    end

    assign o_rd = r_rd;

endmodule

>>> rtl/cdll_alloc.sv
// cdll_alloc: free-slot bitmap of the node pool and lowest-free-slot finder
// isolates the lowest set bit, then encodes it with independent or-trees
// no dependencies
module cdll_alloc #(
    parameter  int CAPACITY = 16,
    localparam int AW       = $clog2(CAPACITY)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [AW-1:0] i_take_idx,
    input  logic          i_release,
    input  logic [AW-1:0] i_release_idx,
    output logic [AW-1:0] o_slot,
    output logic          o_full
);

    logic [CAPACITY-1:0] r_free;
    logic [CAPACITY-1:0] w_iso;

    // slots whose index has bit k set
    function automatic logic [CAPACITY-1:0] bit_mask(input int k);
        logic [CAPACITY-1:0] m;
        for (int i = 0; i < CAPACITY; i++) begin
            m[i] = (((i >> k) & 1) != 0);
        end
        return m;
    endfunction

    always_comb begin
        w_iso = r_free & (~r_free + CAPACITY'(1));
        for (int k = 0; k < AW; k++) begin
            o_slot[k] = |(w_iso & bit_mask(k));
        end
    end

    assign o_full = ~|r_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
        end else begin
            if (i_take) begin
                r_free[i_take_idx] <= 1'b0;
            end
            if (i_release) begin
                r_free[i_release_idx] <= 1'b1;
            end
        end
    end

    a_take_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> r_free[i_take_idx])
        else $error("slot taken that is not free");

    a_release_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_release |-> !r_free[i_release_idx])
        else $error("slot released that is already free");

    a_take_xor_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_take && i_release))
        else $error("take and release in the same cycle");

endmodule

>>> rtl/cursor_doubly_linked_list.sv
// cursor_doubly_linked_list: bounded doubly linked list with a cursor
// item path: idle, link, then data for a data read or wr2 for a second link write,
// then done, which registers the result; one item at a time, the steps set by the
// link read, one write port per link memory, the data read and the output hand-off;
// a held result keeps the next item waiting in done; reset (synchronous, active low)
// empties the list and frees every slot, memories are not cleared
module cursor_doubly_linked_list #(
    parameter  int CAPACITY   = cdll_pkg::DEF_CAPACITY,
    parameter  int DATA_WIDTH = cdll_pkg::DEF_DATA_WIDTH,
    localparam int IOW        = cdll_pkg::IO_WIDTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // item channel in
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [cdll_pkg::OP_WIDTH-1:0]           i_op,
    input  logic signed [IOW-1:0]                   i_value,
    // result channel out
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [cdll_pkg::STATUS_WIDTH-1:0]       o_status,
    output logic                                    o_cursor_valid,
    output logic signed [IOW-1:0]                   o_cursor_value,
    output logic signed [IOW-1:0]                   o_head_value,
    output logic signed [IOW-1:0]                   o_tail_value,
    output logic [cdll_pkg::COUNT_OUT_WIDTH-1:0]    o_node_count,
    output logic                                    o_list_empty
);

    localparam int AW = $clog2(CAPACITY);       // slot index
    localparam int PW = AW + 1;                 // pointer, room for the null code
    localparam int CW = $clog2(CAPACITY + 1);   // node count
    localparam int OCW = cdll_pkg::COUNT_OUT_WIDTH;
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);

    // one write command for a link memory or the data memory
    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [PW-1:0] data;
    } t_link_wr;

    typedef struct packed {
        logic                  en;
        logic [AW-1:0]         addr;
        logic [DATA_WIDTH-1:0] data;
    } t_data_wr;

    // idle: take an item and read the links of the node it works on
    // link: decide, first writes, issue the data read
    // data: the data word of the new head, tail or cursor node is back
    // wr2: second write into a link memory for inserts
    // done: hand the result to the output register
    typedef enum logic [2:0] {
        S_IDLE,
        S_LINK,
        S_DATA,
        S_WR2,
        S_DONE
    } t_state;

    function automatic logic is_nil(input logic [PW-1:0] p);
        return p >= NIL;
    endfunction

    // null pointers read slot 0, the word is thrown away
    function automatic logic [AW-1:0] to_addr(input logic [PW-1:0] p);
        return is_nil(p) ? '0 : p[AW-1:0];
    endfunction

    // stored word to port width: sign-extend or keep the low bits
    function automatic logic signed [IOW-1:0] to_io(input logic [DATA_WIDTH-1:0] d);
        return IOW'(signed'(d));
    endfunction

    // control state
    t_state                     r_state, n_state;
    logic [PW-1:0]              r_head, n_head;
    logic [PW-1:0]              r_tail, n_tail;
    logic [PW-1:0]              r_cur, n_cur;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_out_valid, n_out_valid;

    // item and working registers
    logic [cdll_pkg::OP_WIDTH-1:0] r_op, n_op;
    logic [DATA_WIDTH-1:0]      r_val, n_val;
    logic [DATA_WIDTH-1:0]      r_hv, n_hv;
    logic [DATA_WIDTH-1:0]      r_tv, n_tv;
    logic [DATA_WIDTH-1:0]      r_cv, n_cv;
    cdll_pkg::t_status          r_status, n_status;
    cdll_pkg::t_load            r_ld, n_ld;
    t_link_wr                   r_b_next, n_b_next;
    t_link_wr                   r_b_prev, n_b_prev;

    // result register
    cdll_pkg::t_status          r_o_status, n_o_status;
    logic                       r_o_cvalid, n_o_cvalid;
    logic signed [IOW-1:0]      r_o_cval, n_o_cval;
    logic signed [IOW-1:0]      r_o_hval, n_o_hval;
    logic signed [IOW-1:0]      r_o_tval, n_o_tval;
    logic [OCW-1:0]             r_o_count, n_o_count;
    logic                       r_o_empty, n_o_empty;

    // memory ports
    t_link_wr                   w_wr_next, w_wr_prev;
    t_data_wr                   w_wr_data;
    logic [AW-1:0]              w_link_ra, w_data_ra;
    logic [PW-1:0]              w_rd_next, w_rd_prev;
    logic [DATA_WIDTH-1:0]      w_rd_data;

    // slot pool
    logic                       w_take, w_release;
    logic [AW-1:0]              w_release_idx;
    logic [AW-1:0]              w_slot;
    logic                       w_full;

    cdll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_next_ram (
        .i_clk (i_clk),
        .i_we  (w_wr_next.en),
        .i_wa  (w_wr_next.addr),
        .i_wd  (w_wr_next.data),
        .i_ra  (w_link_ra),
        .o_rd  (w_rd_next)
    );

    cdll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_prev_ram (
        .i_clk (i_clk),
        .i_we  (w_wr_prev.en),
        .i_wa  (w_wr_prev.addr),
        .i_wd  (w_wr_prev.data),
        .i_ra  (w_link_ra),
        .o_rd  (w_rd_prev)
    );

    cdll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_data_ram (
        .i_clk (i_clk),
        .i_we  (w_wr_data.en),
        .i_wa  (w_wr_data.addr),
        .i_wd  (w_wr_data.data),
        .i_ra  (w_data_ra),
        .o_rd  (w_rd_data)
    );

    cdll_alloc #(.CAPACITY(CAPACITY)) u_alloc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_take_idx    (w_slot),
        .i_release     (w_release),
        .i_release_idx (w_release_idx),
        .o_slot        (w_slot),
        .o_full        (w_full)
    );

    // one item in flight; no memory write is ever in the same cycle as a read
    // of the same memory, so the read-modify-write needs no forwarding
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        logic [PW-1:0] tgt;     // node the item works on
        logic [PW-1:0] nx;
        logic [PW-1:0] pv;
        logic [PW-1:0] slot_p;

        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_cur       = r_cur;
        n_count     = r_count;
        n_op        = r_op;
        n_val       = r_val;
        n_hv        = r_hv;
        n_tv        = r_tv;
        n_cv        = r_cv;
        n_status    = r_status;
        n_ld        = r_ld;
        n_b_next    = r_b_next;
        n_b_prev    = r_b_prev;
        n_o_status  = r_o_status;
        n_o_cvalid  = r_o_cvalid;
        n_o_cval    = r_o_cval;
        n_o_hval    = r_o_hval;
        n_o_tval    = r_o_tval;
        n_o_count   = r_o_count;
        n_o_empty   = r_o_empty;
        w_wr_next   = '0;
        w_wr_prev   = '0;
        w_wr_data   = '0;
        w_link_ra   = '0;
        w_data_ra   = '0;
        w_take      = 1'b0;
        w_release   = 1'b0;
        w_release_idx = '0;
        tgt         = NIL;
        nx          = w_rd_next;
        pv          = w_rd_prev;
        slot_p      = PW'(w_slot);

        // result taken by the sink
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                // link read of the node the op starts from
                priority if (i_op == cdll_pkg::OP_DEL_FIRST) begin
                    w_link_ra = to_addr(r_head);
                end else if (i_op == cdll_pkg::OP_DEL_LAST) begin
                    w_link_ra = to_addr(r_tail);
                end else begin
                    w_link_ra = to_addr(r_cur);
                end
                if (i_in_valid) begin
                    n_op    = i_op;
                    n_val   = DATA_WIDTH'($unsigned(i_value));
                    n_state = S_LINK;
                end
            end

            S_LINK: begin
                n_status = cdll_pkg::ST_OK;
                n_ld     = '0;
                n_b_next = '0;
                n_b_prev = '0;
                n_state  = S_DONE;
                unique case (r_op)
                    cdll_pkg::OP_PUSH_BACK,
                    cdll_pkg::OP_PUSH_FRONT,
                    cdll_pkg::OP_INSERT: begin
                        if (w_full) begin
                            n_status = cdll_pkg::ST_FULL;
                        end else begin
                            w_take    = 1'b1;
                            w_wr_data = '{en: 1'b1, addr: w_slot, data: r_val};
                            n_count   = r_count + CW'(1);
                            priority if (is_nil(r_head)) begin
                                // first node: head, tail and cursor
                                w_wr_next = '{en: 1'b1, addr: w_slot, data: NIL};
                                w_wr_prev = '{en: 1'b1, addr: w_slot, data: NIL};
                                n_head = slot_p;
                                n_tail = slot_p;
                                n_cur  = slot_p;
                                n_hv   = r_val;
                                n_tv   = r_val;
                                n_cv   = r_val;
                            end else if (r_op == cdll_pkg::OP_PUSH_BACK || is_nil(r_cur)) begin
                                // append behind the tail
                                w_wr_next = '{en: 1'b1, addr: w_slot, data: NIL};
                                w_wr_prev = '{en: 1'b1, addr: w_slot, data: r_tail};
                                n_b_next  = '{en: 1'b1, addr: to_addr(r_tail), data: slot_p};
                                n_tail    = slot_p;
                                n_tv      = r_val;
                                n_state   = S_WR2;
                            end else if (r_op == cdll_pkg::OP_PUSH_FRONT) begin
                                w_wr_next = '{en: 1'b1, addr: w_slot, data: r_head};
                                w_wr_prev = '{en: 1'b1, addr: w_slot, data: NIL};
                                n_b_prev  = '{en: 1'b1, addr: to_addr(r_head), data: slot_p};
                                n_head    = slot_p;
                                n_hv      = r_val;
                                n_state   = S_WR2;
                            end else begin
                                // in front of the cursor, pv is the cursor's predecessor
                                w_wr_next = '{en: 1'b1, addr: w_slot, data: r_cur};
                                w_wr_prev = '{en: 1'b1, addr: w_slot, data: pv};
                                n_b_prev  = '{en: 1'b1, addr: to_addr(r_cur), data: slot_p};
                                if (is_nil(pv)) begin
                                    n_head = slot_p;
                                    n_hv   = r_val;
                                end else begin
                                    n_b_next = '{en: 1'b1, addr: to_addr(pv), data: slot_p};
                                end
                                n_cur   = slot_p;
                                n_cv    = r_val;
                                n_state = S_WR2;
                            end
                        end
                    end

                    cdll_pkg::OP_RIGHT,
                    cdll_pkg::OP_LEFT: begin
                        tgt = (r_op == cdll_pkg::OP_RIGHT) ? nx : pv;
                        priority if (is_nil(r_cur)) begin
                            n_status = cdll_pkg::ST_EMPTY;
                        end else if (is_nil(tgt)) begin
                            n_status = cdll_pkg::ST_END;
                        end else begin
                            n_cur     = tgt;
                            w_data_ra = to_addr(tgt);
                            n_ld      = '{head: 1'b0, tail: 1'b0, cur: 1'b1};
                            n_state   = S_DATA;
                        end
                    end

                    cdll_pkg::OP_DEL_FIRST,
                    cdll_pkg::OP_DEL_LAST,
                    cdll_pkg::OP_DEL_CURSOR: begin
                        priority if (r_op == cdll_pkg::OP_DEL_FIRST) begin
                            tgt = r_head;
                        end else if (r_op == cdll_pkg::OP_DEL_LAST) begin
                            tgt = r_tail;
                        end else begin
                            tgt = r_cur;
                        end
                        if (is_nil(r_head) || is_nil(tgt)) begin
                            n_status = cdll_pkg::ST_EMPTY;
                        end else begin
                            w_release     = 1'b1;
                            w_release_idx = to_addr(tgt);
                            n_count       = r_count - CW'(1);
                            if (is_nil(pv) && is_nil(nx)) begin
                                // only node gone
                                n_head = NIL;
                                n_tail = NIL;
                                n_cur  = NIL;
                                n_hv   = '0;
                                n_tv   = '0;
                                n_cv   = '0;
                            end else begin
                                // the one neighbor whose word is needed
                                w_data_ra = is_nil(nx) ? to_addr(pv) : to_addr(nx);
                                if (is_nil(pv)) begin
                                    n_head    = nx;
                                    n_ld.head = 1'b1;
                                end else begin
                                    w_wr_next = '{en: 1'b1, addr: to_addr(pv), data: nx};
                                end
                                if (is_nil(nx)) begin
                                    n_tail    = pv;
                                    n_ld.tail = 1'b1;
                                end else begin
                                    w_wr_prev = '{en: 1'b1, addr: to_addr(nx), data: pv};
                                end
                                // cursor on the removed node steps to the next one,
                                // or back to the new tail
                                if (r_cur == tgt) begin
                                    n_cur    = is_nil(nx) ? pv : nx;
                                    n_ld.cur = 1'b1;
                                end
                                if (n_ld.head || n_ld.tail || n_ld.cur) begin
                                    n_state = S_DATA;
                                end
                            end
                        end
                    end

                    cdll_pkg::OP_CUR_FIRST,
                    cdll_pkg::OP_CUR_LAST: begin
                        if (is_nil(r_head)) begin
                            n_status = cdll_pkg::ST_EMPTY;
                        end else if (r_op == cdll_pkg::OP_CUR_FIRST) begin
                            n_cur = r_head;
                            n_cv  = r_hv;
                        end else begin
                            n_cur = r_tail;
                            n_cv  = r_tv;
                        end
                    end

                    default: begin
                        // unused codes leave everything as is
                    end
                endcase
            end

            S_DATA: begin
                if (r_ld.head) begin
                    n_hv = w_rd_data;
                end
                if (r_ld.tail) begin
                    n_tv = w_rd_data;
                end
                if (r_ld.cur) begin
                    n_cv = w_rd_data;
                end
                n_state = S_DONE;
            end

            S_WR2: begin
                w_wr_next = r_b_next;
                w_wr_prev = r_b_prev;
                n_state   = S_DONE;
            end

            S_DONE: begin
                // wait here while an older result is still held
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_cvalid  = !is_nil(r_cur);
                    n_o_cval    = is_nil(r_cur) ? '0 : to_io(r_cv);
                    n_o_hval    = is_nil(r_head) ? '0 : to_io(r_hv);
                    n_o_tval    = is_nil(r_tail) ? '0 : to_io(r_tv);
                    n_o_count   = OCW'(r_count);
                    n_o_empty   = is_nil(r_head);
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_cur       <= NIL;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_hv        <= '0;
            r_tv        <= '0;
            r_cv        <= '0;
            r_ld        <= '0;
            r_b_next    <= '0;
            r_b_prev    <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_cur       <= n_cur;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_hv        <= n_hv;
            r_tv        <= n_tv;
            r_cv        <= n_cv;
            r_ld        <= n_ld;
            r_b_next    <= n_b_next;
            r_b_prev    <= n_b_prev;
        end
        // payload, no reset needed
        r_op       <= n_op;
        r_val      <= n_val;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_cvalid <= n_o_cvalid;
        r_o_cval   <= n_o_cval;
        r_o_hval   <= n_o_hval;
        r_o_tval   <= n_o_tval;
        r_o_count  <= n_o_count;
        r_o_empty  <= n_o_empty;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_cursor_valid = r_o_cvalid;
    assign o_cursor_value = r_o_cval;
    assign o_head_value   = r_o_hval;
    assign o_tail_value   = r_o_tval;
    assign o_node_count   = r_o_count;
    assign o_list_empty   = r_o_empty;

    // head and tail are null together
    a_ends_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_nil(r_head) == is_nil(r_tail))
        else $error("head and tail disagree on an empty list");

    // count tracks emptiness
    a_count_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == is_nil(r_head))
        else $error("node count disagrees with head pointer");

    // a non-empty list always has a cursor
    a_cursor_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !is_nil(r_head) |-> !is_nil(r_cur))
        else $error("cursor null on a non-empty list");

endmodule
